// ----- rtl/nmea_gga_pkg.sv -----
// ----------------------------------------------------------------------------
// nmea_gga_pkg
// Shared types and constants of the NMEA GGA position extractor.
// ----------------------------------------------------------------------------
package nmea_gga_pkg;

  // Default limit on characters kept per coordinate field
  localparam int FIELD_CHARS_DEFAULT = 15;

  // Fixed payload widths
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int INDEX_W = 4;

  // Field kind codes
  localparam logic [KIND_W-1:0] KIND_LAT_CHAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LAT_HEM  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LON_CHAR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LON_HEM  = 2'd3;

  // ASCII characters the parser looks for
  localparam logic [BYTE_W-1:0] CHR_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CHR_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CHR_G      = 8'h47;
  localparam logic [BYTE_W-1:0] CHR_P      = 8'h50;
  localparam logic [BYTE_W-1:0] CHR_A      = 8'h41;
  localparam logic [BYTE_W-1:0] CHR_SPACE  = 8'h20;

  // One extracted position character
  typedef struct packed {
    logic [KIND_W-1:0]  field_kind;
    logic [BYTE_W-1:0]  char_value;
    logic [INDEX_W-1:0] char_index;
    logic               sentence_last;
  } pos_word_t;

  // Parser to output buffer: a word offered for storage
  typedef struct packed {
    logic      push;
    pos_word_t word;
  } pos_push_t;

endpackage

// ----- rtl/nmea_gga_byte_if.sv -----
// ----------------------------------------------------------------------------
// nmea_gga_byte_if
// Byte channel carrying the received NMEA stream.
// ----------------------------------------------------------------------------
interface nmea_gga_byte_if
  import nmea_gga_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/nmea_gga_pos_if.sv -----
// ----------------------------------------------------------------------------
// nmea_gga_pos_if
// Result channel carrying extracted position characters.
// ----------------------------------------------------------------------------
interface nmea_gga_pos_if
  import nmea_gga_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  field_kind;
  logic [BYTE_W-1:0]  char_value;
  logic [INDEX_W-1:0] char_index;
  logic               sentence_last;

  modport source (output valid, output field_kind, output char_value,
                  output char_index, output sentence_last, input ready);
  modport sink   (input valid, input field_kind, input char_value,
                  input char_index, input sentence_last, output ready);
endinterface

// ----- rtl/nmea_gga_position_extractor.sv -----
// ----------------------------------------------------------------------------
// nmea_gga_position_extractor
// Pulls latitude and longitude characters out of NMEA GGA sentences.
// ----------------------------------------------------------------------------
// Feed the raw NMEA byte stream in on rx, one byte per word. The block hunts
// for '$', checks the header "GPGGA,", skips the time field and then sends
// out on pos the latitude characters, the latitude hemisphere byte, the
// longitude characters and the longitude hemisphere byte, the last marked
// with sentence_last. Commas that end a coordinate field are never sent,
// and characters beyond FIELD_CHARS in one field are dropped. rx accepts a
// word every cycle while pos keeps draining, and an accepted byte reaches
// pos through the input register and then the output register. A stalled
// pos fills a two-word output buffer before rx is held off.
// ----------------------------------------------------------------------------
module nmea_gga_position_extractor
  import nmea_gga_pkg::*;
#(
  parameter int FIELD_CHARS = FIELD_CHARS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  nmea_gga_byte_if.sink  rx,
  nmea_gga_pos_if.source pos
);

  pos_push_t offer;
  logic      room;

  // Parse: register the byte, step the sentence state machine
  nmea_gga_parser #(
    .FIELD_CHARS (FIELD_CHARS)
  ) u_parser (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .room  (room),
    .offer (offer)
  );

  // Hold results until the consumer takes them
  nmea_gga_out_buf u_out_buf (
    .clk   (clk),
    .rst   (rst),
    .offer (offer),
    .room  (room),
    .pos   (pos)
  );

endmodule

// ----- rtl/nmea_gga_parser.sv -----
// ----------------------------------------------------------------------------
// nmea_gga_parser
// Input register and sentence state machine; offers one word per byte at most.
// ----------------------------------------------------------------------------
module nmea_gga_parser
  import nmea_gga_pkg::*;
#(
  parameter int FIELD_CHARS = FIELD_CHARS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  nmea_gga_byte_if.sink        rx,
  input  logic                 room,
  output pos_push_t            offer
);

  localparam int CW = $clog2(FIELD_CHARS + 1);
  localparam int EW = (CW > INDEX_W) ? CW : INDEX_W;

  localparam logic [3:0] PH_HUNT      = 4'd0;
  localparam logic [3:0] PH_HDR_G1    = 4'd1;
  localparam logic [3:0] PH_HDR_P     = 4'd2;
  localparam logic [3:0] PH_HDR_G2    = 4'd3;
  localparam logic [3:0] PH_HDR_G3    = 4'd4;
  localparam logic [3:0] PH_HDR_A     = 4'd5;
  localparam logic [3:0] PH_HDR_COMMA = 4'd6;
  localparam logic [3:0] PH_SKIP_TIME = 4'd7;
  localparam logic [3:0] PH_LAT       = 4'd8;
  localparam logic [3:0] PH_LAT_HEM   = 4'd9;
  localparam logic [3:0] PH_SKIP_MID  = 4'd10;
  localparam logic [3:0] PH_LON       = 4'd11;
  localparam logic [3:0] PH_LON_HEM   = 4'd12;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic [3:0]        phase;
  logic [3:0]        phase_next;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [EW-1:0]     count_wide;
  logic [BYTE_W-1:0] hdr_char;
  logic              fire;
  logic              emit;
  pos_word_t         word;

  assign fire     = in_valid && room;
  assign rx.ready = !in_valid || fire;

  // Hold the received byte until the parser can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  // Expected header character for each header phase
  always_comb begin
    unique case (phase)
      PH_HDR_G1:    hdr_char = CHR_G;
      PH_HDR_P:     hdr_char = CHR_P;
      PH_HDR_G2:    hdr_char = CHR_G;
      PH_HDR_G3:    hdr_char = CHR_G;
      PH_HDR_A:     hdr_char = CHR_A;
      PH_HDR_COMMA: hdr_char = CHR_COMMA;
      default:      hdr_char = CHR_SPACE;
    endcase
  end

  assign count_wide = EW'(count);

  always_comb begin
    phase_next         = phase;
    count_next         = count;
    emit               = 1'b0;
    word.field_kind    = KIND_LAT_CHAR;
    word.char_value    = in_byte;
    word.char_index    = '0;
    word.sentence_last = 1'b0;
    unique case (phase)
      PH_HUNT: begin
        if (in_byte == CHR_DOLLAR) phase_next = PH_HDR_G1;
      end
      PH_HDR_G1, PH_HDR_P, PH_HDR_G2, PH_HDR_G3, PH_HDR_A, PH_HDR_COMMA: begin
        if (in_byte == hdr_char) begin
          phase_next = phase + 4'd1;
        end else if (in_byte == CHR_DOLLAR) begin
          phase_next = PH_HDR_G1;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_SKIP_TIME, PH_SKIP_MID: begin
        if (in_byte == CHR_COMMA) begin
          phase_next = (phase == PH_SKIP_TIME) ? PH_LAT : PH_LON;
          count_next = '0;
        end
      end
      PH_LAT, PH_LON: begin
        word.field_kind = (phase == PH_LAT) ? KIND_LAT_CHAR : KIND_LON_CHAR;
        word.char_index = count_wide[INDEX_W-1:0];
        if (in_byte == CHR_COMMA) begin
          phase_next = (phase == PH_LAT) ? PH_LAT_HEM : PH_LON_HEM;
          count_next = '0;
        end else if (count < CW'(FIELD_CHARS)) begin
          emit       = 1'b1;
          count_next = count + CW'(1);
        end
      end
      PH_LAT_HEM: begin
        emit            = 1'b1;
        word.field_kind = KIND_LAT_HEM;
        phase_next      = PH_SKIP_MID;
      end
      PH_LON_HEM: begin
        emit               = 1'b1;
        word.field_kind    = KIND_LON_HEM;
        word.sentence_last = 1'b1;
        phase_next         = PH_HUNT;
        count_next         = '0;
      end
      default: begin
        phase_next = PH_HUNT;
        count_next = '0;
      end
    endcase
  end

  // Advance the state machine once per consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      count <= '0;
    end else if (fire) begin
      phase <= phase_next;
      count <= count_next;
    end
  end

  assign offer.push = fire && emit;
  assign offer.word = word;

endmodule

// ----- rtl/nmea_gga_out_buf.sv -----
// ----------------------------------------------------------------------------
// nmea_gga_out_buf
// Two-word output register with skid slot; room depends on registers only.
// ----------------------------------------------------------------------------
module nmea_gga_out_buf
  import nmea_gga_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  pos_push_t       offer,
  output logic            room,
  nmea_gga_pos_if.source  pos
);

  logic      head_valid;
  pos_word_t head;
  logic      skid_valid;
  pos_word_t skid;
  logic      pop;

  assign pop  = head_valid && pos.ready;
  assign room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          head       <= skid;
          skid_valid <= offer.push;
          skid       <= offer.word;
        end else begin
          head_valid <= offer.push;
          head       <= offer.word;
        end
      end else if (offer.push) begin
        if (!head_valid) begin
          head_valid <= 1'b1;
          head       <= offer.word;
        end else begin
          skid_valid <= 1'b1;
          skid       <= offer.word;
        end
      end
    end
  end

  assign pos.valid         = head_valid;
  assign pos.field_kind    = head.field_kind;
  assign pos.char_value    = head.char_value;
  assign pos.char_index    = head.char_index;
  assign pos.sentence_last = head.sentence_last;

endmodule
